// File: rtl/vfsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfsm_pkg
// types and constants shared by the frame stream monitor modules
// ----------------------------------------------------------------------------
package vfsm_pkg;

  localparam int unsigned TsW    = 32;
  localparam int unsigned BytesW = 24;
  localparam int unsigned QpW    = 6;
  localparam int unsigned SfW    = 4;
  localparam int unsigned RateW  = 40;
  localparam int unsigned CntW   = 9;
  localparam int unsigned NumW   = 64;

  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};
  localparam logic [23:0] UsBits = 24'd8000000;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegGap    = 2'd1;
  localparam logic [1:0] RegQp     = 2'd2;
  localparam logic [1:0] RegSpike  = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StWrite,
    StScan,
    StMul,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic store;
    logic scan_start;
    logic scan_step;
    logic mul;
    logic div_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/vfsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfsm_ctrl
// sequencer for store, window scan, multiply and serial divide
// ----------------------------------------------------------------------------
module vfsm_ctrl
  import vfsm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StWrite;
      StWrite: state_d = StScan;
      StScan:  if (stat_i.scan_done) state_d = StMul;
      StMul:   state_d = StDiv;
      StDiv:   if (stat_i.div_done) state_d = StOut;
      StOut:   if (!stat_i.out_busy) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        ctrl_o.load  = in_valid_i;
      end
      StWrite: begin
        ctrl_o.store      = 1'b1;
        ctrl_o.scan_start = 1'b1;
      end
      StScan:  ctrl_o.scan_step = 1'b1;
      StMul:   ctrl_o.mul = 1'b1;
      StDiv:   ctrl_o.div_step = 1'b1;
      StOut:   ctrl_o.finish = !stat_i.out_busy;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
    end else begin
      assert (!(state_q == StIdle && state_d == StWrite) || in_valid_i)
        else $error("start without request");
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle)
    else $error("ready outside idle");
  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == StWrite)
    else $error("load not followed by write");
  a_div_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.mul |=> state_q == StDiv)
    else $error("multiply not followed by divide");

endmodule

// File: rtl/vfsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfsm_datapath
// history ring, anomaly flags, window scan and bitrate divider
// ----------------------------------------------------------------------------
module vfsm_datapath
  import vfsm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic [TsW-1:0]    ts_i,
  input  logic [BytesW-1:0] bytes_i,
  input  logic [QpW-1:0]    qp_i,
  input  logic [TsW-1:0]    window_us_i,
  input  logic [TsW-1:0]    gap_limit_us_i,
  input  logic [QpW-1:0]    qp_limit_i,
  input  logic [SfW-1:0]    spike_factor_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [135:0]      out_data_o
);

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW = BytesW + HCW;
  localparam logic [HCW-1:0] Depth = HCW'(HISTORY_DEPTH);

  logic [TsW-1:0]    mem_t [HISTORY_DEPTH];
  logic [BytesW-1:0] mem_s [HISTORY_DEPTH];

  logic [TsW-1:0]    ts_q;
  logic [BytesW-1:0] bytes_q;
  logic [QpW-1:0]    qp_q;
  logic [HCW-1:0]    count_q;
  logic [AW-1:0]     head_q;
  logic              prev_valid_q;
  logic [TsW-1:0]    prev_time_q;
  logic [BytesW-1:0] prev_size_q;
  logic              drop_q, spike_q, qdrop_q;

  logic [AW-1:0]     ridx_q;
  logic [HCW-1:0]    left_q;
  logic              rvalid_q;
  logic [TsW-1:0]    rt_q;
  logic [BytesW-1:0] rs_q;
  logic [TsW-1:0]    start_q;
  logic [HCW-1:0]    kept_q;
  logic [SumW-1:0]   total_q;
  logic [TsW-1:0]    first_q;

  logic [NumW-1:0]   rem_q, quo_q, num_q;
  logic [TsW-1:0]    dur_q;
  logic [6:0]        dcnt_q;
  logic              dur_ok_q;

  logic              out_valid_q;
  logic [135:0]      out_q;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    inc = (HCW'(a) + HCW'(1) >= Depth) ? '0 : a + AW'(1);
  endfunction

  // frame capture and flags
  logic [27:0] spike_lim;
  logic signed [TsW:0] gap;
  assign spike_lim = 28'(spike_factor_i) * 28'(prev_size_q);
  assign gap = $signed({1'b0, ts_q}) - $signed({1'b0, prev_time_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ts_q    <= ts_i;
      bytes_q <= bytes_i;
      qp_q    <= qp_i;
    end
    if (ctrl_i.store) begin
      mem_t[head_q] <= ts_q;
      mem_s[head_q] <= bytes_q;
    end
    rt_q <= mem_t[ridx_q];
    rs_q <= mem_s[ridx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      head_q       <= '0;
      prev_valid_q <= 1'b0;
      prev_time_q  <= '0;
      prev_size_q  <= '0;
    end else begin
      if (ctrl_i.store) begin
        head_q <= inc(head_q);
        if (count_q < Depth) count_q <= count_q + HCW'(1);
      end
      if (ctrl_i.finish) begin
        prev_valid_q <= 1'b1;
        prev_time_q  <= ts_q;
        prev_size_q  <= bytes_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      drop_q  <= prev_valid_q && (gap > $signed({1'b0, gap_limit_us_i}));
      spike_q <= prev_valid_q && (28'(bytes_q) > spike_lim);
      qdrop_q <= qp_q > qp_limit_i;
      start_q <= (window_us_i > ts_q) ? '0 : ts_q - window_us_i;
    end
  end

  // scan: read address is issued, and its data registered, ahead of the accumulate
  logic [AW-1:0] oldest;
  logic [HCW-1:0] cnt_new;
  logic [HCW:0] oldest_w;
  assign cnt_new  = (count_q < Depth) ? count_q + HCW'(1) : count_q;
  assign oldest_w = {1'b0, inc(head_q)} + {1'b0, Depth} - {1'b0, cnt_new};
  assign oldest   = (oldest_w >= {1'b0, Depth}) ? AW'(oldest_w - {1'b0, Depth})
                                                : AW'(oldest_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      rvalid_q <= 1'b0;
      ridx_q   <= '0;
    end else if (ctrl_i.scan_start) begin
      ridx_q   <= oldest;
      left_q   <= cnt_new;
      rvalid_q <= 1'b0;
    end else if (ctrl_i.scan_step) begin
      rvalid_q <= left_q != '0;
      if (left_q != '0) begin
        left_q <= left_q - HCW'(1);
        ridx_q <= inc(ridx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_start) begin
      kept_q  <= '0;
      total_q <= '0;
      first_q <= '0;
    end else if (ctrl_i.scan_step && rvalid_q && rt_q >= start_q) begin
      if (kept_q == '0) first_q <= rt_q;
      kept_q  <= kept_q + HCW'(1);
      total_q <= total_q + SumW'(rs_q);
    end
  end

  assign stat_o.scan_done = (left_q == '0) && !rvalid_q && ctrl_i.scan_step;

  // multiply then restoring divide, one quotient bit a cycle
  logic [NumW:0] trial;
  assign trial = {rem_q, num_q[NumW-1]} - {{(NumW-TsW+1){1'b0}}, dur_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      num_q    <= NumW'(total_q) * NumW'(UsBits);
      dur_q    <= ts_q - first_q;
      dur_ok_q <= (kept_q != '0) && ($signed({1'b0, ts_q}) > $signed({1'b0, first_q}));
      rem_q    <= '0;
      quo_q    <= '0;
      dcnt_q   <= 7'(NumW);
    end else if (ctrl_i.div_step && dcnt_q != '0) begin
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumW-2:0], num_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
      num_q  <= {num_q[NumW-2:0], 1'b0};
      dcnt_q <= dcnt_q - 7'd1;
    end
  end

  assign stat_o.div_done = ctrl_i.div_step && dcnt_q == '0;

  // result register
  logic [RateW-1:0] avg, flr, peak;
  logic [RateW:0]   psum;
  logic [CntW-1:0]  kept_sat;
  always_comb begin
    avg  = (!dur_ok_q) ? '0 : (quo_q > NumW'(RateMax)) ? RateMax : quo_q[RateW-1:0];
    flr  = avg >> 1;
    psum = {1'b0, avg} + {1'b0, flr};
    peak = psum[RateW] ? RateMax : psum[RateW-1:0];
    kept_sat = (32'(kept_q) > 32'd511) ? '1 : CntW'(kept_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      out_q <= {4'd0, kept_sat, flr, peak, avg, qdrop_q, spike_q, drop_q};
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish |=> out_valid_q)
    else $error("finished result not presented");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("history count overflow");
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= Depth)
    else $error("kept count overflow");

endmodule

// File: rtl/video_frame_stream_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_frame_stream_monitor
// per-frame anomaly flags and windowed bitrate of a coded video stream
// ----------------------------------------------------------------------------
// Frame records come in on the s_axis channel, one request per frame, and
// one result request leaves on m_axis for each of them. Registers (index 0
// window, 1 gap limit, 2 qp limit, 3 spike factor) are written through the
// cfg channel; the user must write them only while the block is idle, as
// the block does not enforce it. Each frame is stored in a ring of
// HISTORY_DEPTH entries, then the ring is scanned one entry a cycle through
// its single read port, the byte total is scaled by one multiply and divided
// by the time from the first kept frame to the new one, one quotient bit a
// cycle. The scan covers the ring fill with the new frame (at most 256 at
// the default depth). One frame is worked on at a time; s_axis_tready is
// high only while idle.
// Reset clears the ring fill count and the previous frame and returns the
// registers to their defaults; ring contents are not cleared. When
// m_axis_tready is low the result is held; the next frame may still be
// taken, but its result waits in the last step until the held one leaves.
// ----------------------------------------------------------------------------
module video_frame_stream_monitor
  import vfsm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // frame_timestamp, frame_bytes, frame_qp
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // drop flag, spike flag, qp flag,
                                       // avg, peak, floor bitrate, frames_in_window
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;
  logic [TsW-1:0] window_q, gap_q;
  logic [QpW-1:0] qp_lim_q;
  logic [SfW-1:0] sf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 32'd1000000;
      gap_q    <= 32'd66667;
      qp_lim_q <= 6'd40;
      sf_q     <= 4'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWindow: window_q <= cfg_data_i;
        RegGap:    gap_q    <= cfg_data_i;
        RegQp:     qp_lim_q <= cfg_data_i[QpW-1:0];
        RegSpike:  sf_q     <= cfg_data_i[SfW-1:0];
        default:   ;
      endcase
    end
  end

  vfsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  vfsm_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .ts_i           (s_axis_tdata[31:0]),
    .bytes_i        (s_axis_tdata[55:32]),
    .qp_i           (s_axis_tdata[61:56]),
    .window_us_i    (window_q),
    .gap_limit_us_i (gap_q),
    .qp_limit_i     (qp_lim_q),
    .spike_factor_i (sf_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the video frame stream monitor
// ----------------------------------------------------------------------------
// A short table of frame records (extremes, equal and backward timestamps,
// a spike just over the factor, QP over the limit) is followed by random
// frame streams of regular spacing with noise mixed in, over several
// register settings and idling phases. Every result request is checked
// field by field against the frame-level model in this bench or a table row.
// ----------------------------------------------------------------------------
module testbench;
  import vfsm_pkg::*;

  typedef struct packed {
    logic             drop;
    logic             spike;
    logic             qdrop;
    logic [RateW-1:0] avg;
    logic [RateW-1:0] peak;
    logic [RateW-1:0] flr;
    logic [CntW-1:0]  fiw;
  } frame_stats_t;

  typedef struct {
    logic [TsW-1:0]    ts;
    logic [BytesW-1:0] bytes;
    logic [QpW-1:0]    qp;
    bit                typed;
    frame_stats_t      stats;
  } frame_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = RegWindow;
  logic [31:0]  cfg_data_i = '0;

  video_frame_stream_monitor uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame-level model state
  logic [TsW-1:0]    ring_ts [256];
  logic [BytesW-1:0] ring_bytes [256];
  logic [8:0]        ring_count;
  logic [7:0]        ring_head;
  bit                have_prev;
  logic [TsW-1:0]    prev_ts;
  logic [BytesW-1:0] prev_bytes;
  logic [31:0]       window_us, gap_limit_us;
  logic [QpW-1:0]    qp_limit;
  logic [SfW-1:0]    spike_factor;

  frame_stats_t expected_stats[$];
  int           mismatches = 0;
  int           frames_sent = 0;
  int           results_seen = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  longint       cycles = 0;
  logic [TsW-1:0] stream_ts = '0;

  function automatic frame_stats_t frame_monitor_step(logic [TsW-1:0] ts,
                                                      logic [BytesW-1:0] bytes,
                                                      logic [QpW-1:0] qp);
    frame_stats_t r;
    logic [TsW-1:0] start, first;
    logic [7:0] idx;
    logic [63:0] total, avg;
    int kept;
    r = '0;
    total = 0;
    kept = 0;
    first = '0;
    ring_ts[ring_head] = ts;
    ring_bytes[ring_head] = bytes;
    ring_head = ring_head + 8'd1;
    if (ring_count < 9'd256) ring_count = ring_count + 9'd1;
    if (have_prev) begin
      r.drop = ($signed({1'b0, ts}) - $signed({1'b0, prev_ts})) >
               $signed({1'b0, gap_limit_us});
      r.spike = {4'd0, bytes} > (spike_factor * {4'd0, prev_bytes});
    end
    r.qdrop = qp > qp_limit;
    start = (window_us > ts) ? '0 : ts - window_us;
    idx = ring_head - ring_count[7:0];
    for (int i = 0; i < ring_count; i++) begin
      if (ring_ts[idx] >= start) begin
        if (kept == 0) first = ring_ts[idx];
        kept++;
        total += ring_bytes[idx];
      end
      idx = idx + 8'd1;
    end
    if (kept > 0 && ts > first) begin
      avg = (total * 64'd8000000) / (ts - first);
      if (avg > RateMax) avg = RateMax;
      r.avg = avg[RateW-1:0];
      r.flr = r.avg >> 1;
      avg = r.avg + r.flr;
      r.peak = (avg > RateMax) ? RateMax : avg[RateW-1:0];
    end
    r.fiw = CntW'(kept);
    have_prev = 1'b1;
    prev_ts = ts;
    prev_bytes = bytes;
    return r;
  endfunction

  task automatic write_registers(logic [31:0] win, logic [31:0] gap,
                                 logic [QpW-1:0] qpl, logic [SfW-1:0] sf);
    logic [31:0] vals [4];
    vals = '{win, gap, {26'd0, qpl}, {28'd0, sf}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    window_us = win;
    gap_limit_us = gap;
    qp_limit = qpl;
    spike_factor = sf;
  endtask

  task automatic send_frame(logic [TsW-1:0] ts, logic [BytesW-1:0] bytes,
                            logic [QpW-1:0] qp, bit typed, frame_stats_t typed_stats);
    frame_stats_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, qp, bytes, ts};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = frame_monitor_step(ts, bytes, qp);
    expected_stats.insert(expected_stats.size(), typed ? typed_stats : r);
    frames_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // result side: check and random stall
  always @(posedge clk_i) begin
    frame_stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got.drop = m_axis_tdata[0];
      got.spike = m_axis_tdata[1];
      got.qdrop = m_axis_tdata[2];
      got.avg = m_axis_tdata[42:3];
      got.peak = m_axis_tdata[82:43];
      got.flr = m_axis_tdata[122:83];
      got.fiw = m_axis_tdata[131:123];
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result request %h", m_axis_tdata);
      end else begin
        want = expected_stats[0];
        expected_stats.delete(0);
        if (got.drop !== want.drop || got.spike !== want.spike ||
            got.qdrop !== want.qdrop || got.avg !== want.avg ||
            got.peak !== want.peak || got.flr !== want.flr ||
            got.fiw !== want.fiw) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: exp d%b s%b q%b avg %0d peak %0d floor %0d n %0d",
                     results_seen, want.drop, want.spike, want.qdrop, want.avg,
                     want.peak, want.flr, want.fiw);
            $display("  got d%b s%b q%b avg %0d peak %0d floor %0d n %0d",
                     got.drop, got.spike, got.qdrop, got.avg, got.peak,
                     got.flr, got.fiw);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  frame_row_t frame_table [18] = '{
    '{32'd1000, 24'd5000, 6'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 40'd0, 40'd0, 40'd0, 9'd1}},
    '{32'd34333, 24'd5000, 6'd40, 1'b0, '0},
    '{32'd67666, 24'd15001, 6'd41, 1'b0, '0},
    '{32'd67666, 24'd0, 6'd63, 1'b0, '0},
    '{32'd134333, 24'd1, 6'd0, 1'b0, '0},
    '{32'd134334, 24'd3, 6'd1, 1'b0, '0},
    '{32'd201001, 24'd4, 6'd2, 1'b0, '0},
    '{32'd100000, 24'd9, 6'd42, 1'b0, '0},
    '{32'd133333, 24'hFFFFFF, 6'd39, 1'b0, '0},
    '{32'd166666, 24'hFFFFFF, 6'd40, 1'b0, '0},
    '{32'd166667, 24'hFFFFFF, 6'd63, 1'b0, '0},
    '{32'hFFFFFFFF, 24'hAAAAAA, 6'h2A, 1'b0, '0},
    '{32'd0, 24'h555555, 6'h15, 1'b0, '0},
    '{32'hFFFF0000, 24'd1, 6'd0, 1'b0, '0},
    '{32'hFFFF8235, 24'd1000000, 6'd20, 1'b0, '0},
    '{32'hFFFFFFFE, 24'd3000000, 6'd30, 1'b0, '0},
    '{32'h80000000, 24'd2, 6'd50, 1'b0, '0},
    '{32'h7FFFFFFF, 24'd7, 6'd10, 1'b0, '0}
  };

  initial begin
    logic [31:0] phase_win [5];
    logic [31:0] phase_gap [5];
    logic [QpW-1:0] phase_qp [5];
    logic [SfW-1:0] phase_sf [5];
    int phase_idle [5];
    int phase_stall [5];
    logic [TsW-1:0] ts;
    logic [BytesW-1:0] bytes;
    logic [QpW-1:0] qp;
    phase_win = '{32'd100000, 32'd0, 32'hFFFFFFFF, 32'd1000000, 32'd5000000};
    phase_gap = '{32'd40000, 32'd0, 32'hFFFFFFFF, 32'd66667, 32'd100000};
    phase_qp = '{6'd20, 6'd0, 6'd63, 6'd40, 6'd30};
    phase_sf = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd3};
    phase_idle = '{0, 87, 0, 18, 0};
    phase_stall = '{0, 0, 87, 18, 0};
    ring_count = '0;
    ring_head = '0;
    have_prev = 1'b0;
    prev_ts = '0;
    prev_bytes = '0;
    window_us = 32'd1000000;
    gap_limit_us = 32'd66667;
    qp_limit = 6'd40;
    spike_factor = 4'd3;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (frame_table[i])
      send_frame(frame_table[i].ts, frame_table[i].bytes, frame_table[i].qp,
                 frame_table[i].typed, frame_table[i].stats);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_registers(phase_win[p], phase_gap[p], phase_qp[p], phase_sf[p]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < 266; n++) begin
        if ($urandom_range(99) < 80) begin
          if ($urandom_range(9) == 0) stream_ts = stream_ts + $urandom_range(200000, 60000);
          else stream_ts = stream_ts + $urandom_range(36000, 30000);
          ts = stream_ts;
          bytes = ($urandom_range(7) == 0) ? BytesW'($urandom_range(300000, 60000))
                                           : BytesW'($urandom_range(60000, 1000));
          qp = QpW'($urandom_range(50, 15));
        end else begin
          ts = $urandom;
          bytes = BytesW'($urandom);
          qp = QpW'($urandom);
          if ($urandom_range(1) == 0) ts = stream_ts - $urandom_range(100000);
        end
        send_frame(ts, bytes, qp, 1'b0, '0);
        if ($urandom_range(99) == 0) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (expected_stats.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("covered %0d frame requests and %0d results over 6 register settings",
             frames_sent, results_seen);
    $display("with regular, gapped, backward and random timestamps and ring wraparound");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
